// ----- hdl/cgct_pkg.sv -----
// ---------------------------------------------------------------------------
// cgct_pkg: shared types and constants of the cyclic gradient colour table
// Table geometry, stop record layout, sequencer states and index helper.
// ---------------------------------------------------------------------------
package cgct_pkg;

  localparam int TABLE_SIZE     = 256;
  localparam int POSITION_RANGE = 1024;
  localparam int MAX_STOPS      = 16;

  localparam int TBL_AW  = $clog2(TABLE_SIZE);
  localparam int SPAN_W  = TBL_AW + 1;
  localparam int COLOR_W = 8;
  localparam int NUM_W   = COLOR_W + TBL_AW;
  localparam int POS_W   = 10;
  localparam int LOOK_W  = 16;
  localparam int SAW     = $clog2(MAX_STOPS);
  localparam int CNT_W   = $clog2(MAX_STOPS + 1);

  // Request opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic [POS_W-1:0]   pos;
  } stop_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CMP,
    ST_LK_CLR,
    ST_RB_RD0,
    ST_RB_LD0,
    ST_RB_RDM,
    ST_RB_LDM,
    ST_RB_MULA,
    ST_RB_MULB,
    ST_RB_DIVGO,
    ST_RB_DIV,
    ST_RB_WR,
    ST_LK_RD,
    ST_FINISH
  } state_t;

  // Map a stop position (or rotation) onto a table index, modulo the table
  function automatic logic [TBL_AW-1:0] pos_to_index(input logic [POS_W-1:0] pos);
    logic [31:0] p;
    p = (32'(pos) * TABLE_SIZE) / POSITION_RANGE;
    return p[TBL_AW-1:0];
  endfunction

endpackage

// ----- hdl/cgct_div.sv -----
// ---------------------------------------------------------------------------
// cgct_div: bit-serial restoring divider for the interpolation step
// Divides a numerator known to be below 256 * den, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module cgct_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cgct_pkg::NUM_W-1:0]    num,
  input  logic [cgct_pkg::SPAN_W-1:0]   den,
  output logic                          done,
  output logic [cgct_pkg::COLOR_W-1:0]  quo
);

  localparam int CW = cgct_pkg::COLOR_W;
  localparam int RW = cgct_pkg::SPAN_W;

  logic [RW-1:0]         rem_r;
  logic [CW-1:0]         quo_r;
  logic [$clog2(CW)-1:0] cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [RW:0]           trial;
  logic                  fits;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_r, quo_r[CW-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(CW))'(CW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load the upper numerator bits as remainder, shift in the rest
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num[cgct_pkg::NUM_W-1:CW]};
      quo_r <= num[CW-1:0];
    end else if (busy_r) begin
      rem_r <= fits ? RW'(trial - {1'b0, den}) : trial[RW-1:0];
      quo_r <= {quo_r[CW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- hdl/cyclic_gradient_color_table.sv -----
// ---------------------------------------------------------------------------
// cyclic_gradient_color_table: cyclic linear colour gradient lookup table
// Sorted stop store, table rebuild through one shared divider, lookups.
// ---------------------------------------------------------------------------
// One request enters on the in_ stream (op, stop fields, lookup fraction) and
// gives exactly one response on the out_ stream (red, green, blue, status).
// The block works on one request at a time; in_tready is high only while the
// sequencer is idle. A finished response waits in the output register, so the
// next request may be taken while the receiver stalls; a further response is
// held back until the register is free.
// An add moves each larger stop up one place and writes the new stop into the
// slot found; an add to a full store is rejected. A lookup reads the table
// while it is current. The first lookup after the stops changed rebuilds the
// table first: a clearing pass over all TABLE_SIZE entries, a fetch of the
// first stop, then per table entry the bit-serial divider runs three times
// (one per colour), with a set-up per stop.
// rotation is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Reset (rst_n low, synchronous) empties the stop store, zeroes rotation
// and marks the table stale; no clearing pass runs at reset.
// ---------------------------------------------------------------------------
module cyclic_gradient_color_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[1:0], stop_position[11:2], stop_red[19:12], stop_green[27:20],
  // stop_blue[35:28], lookup_value[51:36], zero fill
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], status[24], zero fill
  output logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata
);

  localparam int TBL_AW  = cgct_pkg::TBL_AW;
  localparam int SPAN_W  = cgct_pkg::SPAN_W;
  localparam int NUM_W   = cgct_pkg::NUM_W;
  localparam int CW      = cgct_pkg::COLOR_W;
  localparam int SAW     = cgct_pkg::SAW;
  localparam int CNT_W   = cgct_pkg::CNT_W;
  localparam int LOOK_W  = cgct_pkg::LOOK_W;

  // Request fields
  logic [1:0]                 in_op;
  cgct_pkg::stop_t            in_stop;
  logic [LOOK_W-1:0]          in_lookup;

  assign in_op         = in_tdata[1:0];
  assign in_stop.pos   = in_tdata[11:2];
  assign in_stop.red   = in_tdata[19:12];
  assign in_stop.green = in_tdata[27:20];
  assign in_stop.blue  = in_tdata[35:28];
  assign in_lookup     = in_tdata[51:36];

  // Control and datapath registers
  cgct_pkg::state_t   state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               stale_r, stale_nxt;
  logic [9:0]         rot_r;
  logic               status_r, status_nxt;
  logic               look_r, look_nxt;
  cgct_pkg::stop_t    new_r, new_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [TBL_AW-1:0]  idx_r, idx_nxt;
  logic [TBL_AW-1:0]  clr_r, clr_nxt;
  logic [SAW-1:0]     n_r, n_nxt;
  cgct_pkg::stop_t    cur_r, cur_nxt;
  cgct_pkg::stop_t    nxt_r, nxt_nxt;
  logic [TBL_AW-1:0]  start_r, start_nxt;
  logic [SPAN_W-1:0]  span_r, span_nxt;
  logic [TBL_AW-1:0]  i_r, i_nxt;
  logic [1:0]         ch_r, ch_nxt;
  logic [NUM_W-1:0]   prod_r, prod_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [3*CW-1:0]    pix_r, pix_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [31:0]        out_tdata_r, out_tdata_nxt;

  // Memory ports
  cgct_pkg::stop_t    stop_mem [cgct_pkg::MAX_STOPS];
  logic               stop_we;
  logic [SAW-1:0]     stop_waddr;
  cgct_pkg::stop_t    stop_wdata;
  logic [SAW-1:0]     stop_raddr;
  cgct_pkg::stop_t    stop_q;

  logic [3*CW-1:0]    tbl_mem [cgct_pkg::TABLE_SIZE];
  logic               tbl_we;
  logic [TBL_AW-1:0]  tbl_waddr;
  logic [3*CW-1:0]    tbl_wdata;
  logic               tbl_re;
  logic [3*CW-1:0]    tbl_q;

  // Divider
  logic               div_start;
  logic               div_done;
  logic [CW-1:0]      div_quo;

  logic [CW-1:0]      col_a;
  logic [CW-1:0]      col_b;
  logic [SAW-1:0]     m_idx;
  logic               n_last;
  logic [TBL_AW-1:0]  end_idx;
  logic [TBL_AW-1:0]  base_idx;
  logic [TBL_AW-1:0]  rot_idx;

  cgct_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (span_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Colour channel selection for the current interpolation step
  always_comb begin
    case (ch_r)
      2'd0:    begin col_a = cur_r.red;   col_b = nxt_r.red;   end
      2'd1:    begin col_a = cur_r.green; col_b = nxt_r.green; end
      2'd2:    begin col_a = cur_r.blue;  col_b = nxt_r.blue;  end
      default: begin col_a = '0;          col_b = '0;          end
    endcase
  end

  assign n_last   = (CNT_W'(n_r) + 1'b1) == cnt_r;
  assign m_idx    = n_last ? '0 : SAW'(n_r + 1'b1);
  assign end_idx  = cgct_pkg::pos_to_index(stop_q.pos);
  assign base_idx = in_lookup[LOOK_W-1 -: TBL_AW];
  assign rot_idx  = cgct_pkg::pos_to_index(rot_r);

  // Sequencer: next state, register updates and memory strobes
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    stale_nxt      = stale_r;
    status_nxt     = status_r;
    look_nxt       = look_r;
    new_nxt        = new_r;
    k_nxt          = k_r;
    idx_nxt        = idx_r;
    clr_nxt        = clr_r;
    n_nxt          = n_r;
    cur_nxt        = cur_r;
    nxt_nxt        = nxt_r;
    start_nxt      = start_r;
    span_nxt       = span_r;
    i_nxt          = i_r;
    ch_nxt         = ch_r;
    prod_nxt       = prod_r;
    num_nxt        = num_r;
    pix_nxt        = pix_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    in_tready      = 1'b0;
    stop_we        = 1'b0;
    stop_waddr     = k_r[SAW-1:0];
    stop_wdata     = new_r;
    stop_raddr     = '0;
    tbl_we         = 1'b0;
    tbl_waddr      = clr_r;
    tbl_wdata      = '0;
    tbl_re         = 1'b0;
    div_start      = 1'b0;

    case (state_r)
      cgct_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          status_nxt = 1'b0;
          look_nxt   = 1'b0;
          new_nxt    = in_stop;
          k_nxt      = cnt_r;
          clr_nxt    = '0;
          idx_nxt    = base_idx - rot_idx;
          state_nxt  = cgct_pkg::ST_FINISH;
          case (in_op)
            cgct_pkg::OP_CLEAR: begin
              cnt_nxt   = '0;
              stale_nxt = 1'b1;
            end
            cgct_pkg::OP_ADD: begin
              if (cnt_r == CNT_W'(cgct_pkg::MAX_STOPS)) begin
                status_nxt = 1'b1;
              end else begin
                state_nxt = cgct_pkg::ST_ADD_RD;
              end
            end
            cgct_pkg::OP_LOOKUP: begin
              state_nxt = stale_r ? cgct_pkg::ST_LK_CLR : cgct_pkg::ST_LK_RD;
            end
            default: begin
              state_nxt = cgct_pkg::ST_FINISH;
            end
          endcase
        end
      end

      // Insertion: move larger stops up one place until the slot is found
      cgct_pkg::ST_ADD_RD: begin
        stop_raddr = SAW'(k_r - 1'b1);
        if (k_r == '0) begin
          stop_we   = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          stale_nxt = 1'b1;
          state_nxt = cgct_pkg::ST_FINISH;
        end else begin
          state_nxt = cgct_pkg::ST_ADD_CMP;
        end
      end

      cgct_pkg::ST_ADD_CMP: begin
        stop_we = 1'b1;
        if (stop_q.pos > new_r.pos) begin
          stop_wdata = stop_q;
          k_nxt      = k_r - 1'b1;
          state_nxt  = cgct_pkg::ST_ADD_RD;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          stale_nxt = 1'b1;
          state_nxt = cgct_pkg::ST_FINISH;
        end
      end

      // Clear the table before a rebuild
      cgct_pkg::ST_LK_CLR: begin
        tbl_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == TBL_AW'(cgct_pkg::TABLE_SIZE - 1)) begin
          n_nxt = '0;
          if (cnt_r == '0) begin
            stale_nxt = 1'b0;
            state_nxt = cgct_pkg::ST_LK_RD;
          end else begin
            state_nxt = cgct_pkg::ST_RB_RD0;
          end
        end
      end

      cgct_pkg::ST_RB_RD0: begin
        stop_raddr = '0;
        state_nxt  = cgct_pkg::ST_RB_LD0;
      end

      cgct_pkg::ST_RB_LD0: begin
        cur_nxt   = stop_q;
        state_nxt = cgct_pkg::ST_RB_RDM;
      end

      cgct_pkg::ST_RB_RDM: begin
        stop_raddr = m_idx;
        state_nxt  = cgct_pkg::ST_RB_LDM;
      end

      // Segment set-up: start index and span, a zero span wraps the table
      cgct_pkg::ST_RB_LDM: begin
        nxt_nxt   = stop_q;
        start_nxt = cgct_pkg::pos_to_index(cur_r.pos);
        if (end_idx > cgct_pkg::pos_to_index(cur_r.pos)) begin
          span_nxt = SPAN_W'({1'b0, end_idx} - {1'b0, cgct_pkg::pos_to_index(cur_r.pos)});
        end else begin
          span_nxt = SPAN_W'({1'b0, end_idx} + SPAN_W'(cgct_pkg::TABLE_SIZE)
                             - {1'b0, cgct_pkg::pos_to_index(cur_r.pos)});
        end
        i_nxt     = '0;
        ch_nxt    = '0;
        state_nxt = cgct_pkg::ST_RB_MULA;
      end

      cgct_pkg::ST_RB_MULA: begin
        prod_nxt  = NUM_W'(col_a * (span_r - {1'b0, i_r}));
        state_nxt = cgct_pkg::ST_RB_MULB;
      end

      cgct_pkg::ST_RB_MULB: begin
        num_nxt   = prod_r + NUM_W'(col_b * i_r) + NUM_W'(span_r >> 1);
        state_nxt = cgct_pkg::ST_RB_DIVGO;
      end

      cgct_pkg::ST_RB_DIVGO: begin
        div_start = 1'b1;
        state_nxt = cgct_pkg::ST_RB_DIV;
      end

      cgct_pkg::ST_RB_DIV: begin
        if (div_done) begin
          pix_nxt[ch_r*CW +: CW] = div_quo;
          if (ch_r == 2'd2) begin
            state_nxt = cgct_pkg::ST_RB_WR;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = cgct_pkg::ST_RB_MULA;
          end
        end
      end

      // Write the entry, then advance along the segment or to the next stop, or end the rebuild
      cgct_pkg::ST_RB_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = start_r + i_r;
        tbl_wdata = pix_r;
        ch_nxt    = '0;
        if ({1'b0, i_r} == span_r - 1'b1) begin
          if (n_last) begin
            stale_nxt = 1'b0;
            state_nxt = cgct_pkg::ST_LK_RD;
          end else begin
            n_nxt     = n_r + 1'b1;
            cur_nxt   = nxt_r;
            state_nxt = cgct_pkg::ST_RB_RDM;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = cgct_pkg::ST_RB_MULA;
        end
      end

      cgct_pkg::ST_LK_RD: begin
        tbl_re    = 1'b1;
        look_nxt  = 1'b1;
        state_nxt = cgct_pkg::ST_FINISH;
      end

      // Hold the response until the output register is free
      cgct_pkg::ST_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {7'd0, status_r, look_r ? tbl_q : {3*CW{1'b0}}};
          state_nxt      = cgct_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = cgct_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cgct_pkg::ST_IDLE;
      cnt_r        <= '0;
      stale_r      <= 1'b1;
      rot_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      stale_r      <= stale_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        rot_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    look_r      <= look_nxt;
    new_r       <= new_nxt;
    k_r         <= k_nxt;
    idx_r       <= idx_nxt;
    clr_r       <= clr_nxt;
    n_r         <= n_nxt;
    cur_r       <= cur_nxt;
    nxt_r       <= nxt_nxt;
    start_r     <= start_nxt;
    span_r      <= span_nxt;
    i_r         <= i_nxt;
    ch_r        <= ch_nxt;
    prod_r      <= prod_nxt;
    num_r       <= num_nxt;
    pix_r       <= pix_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // Stop store
  always_ff @(posedge clk) begin
    if (stop_we) begin
      stop_mem[stop_waddr] <= stop_wdata;
    end
    stop_q <= stop_mem[stop_raddr];
  end

  // Colour table
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_q <= tbl_mem[idx_r];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  // The stop count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(cgct_pkg::MAX_STOPS))
    else $error("stop count beyond store depth");

  // A table read only happens on a current table
  a_read_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cgct_pkg::ST_LK_RD |-> !stale_r)
    else $error("table read while stale");

  // An add to a full store is rejected straight away
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_op == cgct_pkg::OP_ADD
      && cnt_r == CNT_W'(cgct_pkg::MAX_STOPS)
    |=> state_r == cgct_pkg::ST_FINISH && status_r && $stable(cnt_r))
    else $error("full store add not rejected");
`endif

endmodule

// ----- dv/tb_cyclic_gradient_color_table.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_cyclic_gradient_color_table: self-checking testbench
// Drives directed and random requests (clear, add stop, look up) through the
// in_ stream, predicts responses with a behavioural gradient table (typed rows
// give their own) and compares each field on the out_ stream. Runs several
// rotation settings and idling patterns, including a long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_cyclic_gradient_color_table;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       status;
  } colour_resp_t;

  typedef struct {
    logic [1:0]  op;
    logic [9:0]  pos;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] frac;
    bit          typed;
    colour_resp_t resp;
  } req_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [9:0]  cfg_wdata = '0;

  // Gradient model state
  int unsigned  grad_pos [cgct_pkg::MAX_STOPS];
  int unsigned  grad_rgb [cgct_pkg::MAX_STOPS][3];
  int unsigned  grad_count;
  int unsigned  grad_table [cgct_pkg::TABLE_SIZE][3];
  bit           grad_stale;
  int unsigned  grad_rot;

  colour_resp_t pending_colours[$];
  int           fail_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           hold_off_req = 1'b0;

  always #5 clk = ~clk;

  cyclic_gradient_color_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Rebuild the cyclic table from the sorted stops
  function automatic void rebuild_gradient();
    int s, e, d, span, idx, m;
    for (int i = 0; i < cgct_pkg::TABLE_SIZE; i++)
      for (int c = 0; c < 3; c++) grad_table[i][c] = 0;
    for (int n = 0; n < grad_count; n++) begin
      m = (n + 1) % grad_count;
      s = grad_pos[n] * cgct_pkg::TABLE_SIZE / cgct_pkg::POSITION_RANGE;
      e = grad_pos[m] * cgct_pkg::TABLE_SIZE / cgct_pkg::POSITION_RANGE;
      d = e - s;
      span = (d > 0) ? d : d + cgct_pkg::TABLE_SIZE;
      for (int i = 0; i < span; i++) begin
        idx = (s + i) % cgct_pkg::TABLE_SIZE;
        for (int c = 0; c < 3; c++)
          grad_table[idx][c] = (grad_rgb[n][c] * (span - i) + grad_rgb[m][c] * i
                                + span / 2) / span;
      end
    end
    grad_stale = 1'b0;
  endfunction

  // Work out the response to one accepted request and update the model
  function automatic colour_resp_t predict_colour(req_row_t q);
    colour_resp_t r;
    int k, base, rot, idx;
    r = '{8'd0, 8'd0, 8'd0, 1'b0};
    case (q.op)
      cgct_pkg::OP_CLEAR: begin
        grad_count = 0;
        grad_stale = 1'b1;
      end
      cgct_pkg::OP_ADD: begin
        if (grad_count >= cgct_pkg::MAX_STOPS) r.status = 1'b1;
        else begin
          k = grad_count;
          while (k > 0 && grad_pos[k-1] > q.pos) begin
            grad_pos[k] = grad_pos[k-1];
            grad_rgb[k] = grad_rgb[k-1];
            k--;
          end
          grad_pos[k] = q.pos % cgct_pkg::POSITION_RANGE;
          grad_rgb[k][0] = q.red;
          grad_rgb[k][1] = q.green;
          grad_rgb[k][2] = q.blue;
          grad_count++;
          grad_stale = 1'b1;
        end
      end
      cgct_pkg::OP_LOOKUP: begin
        base = (int'(q.frac) * cgct_pkg::TABLE_SIZE) >> 16;
        rot = (grad_rot * cgct_pkg::TABLE_SIZE / cgct_pkg::POSITION_RANGE)
              % cgct_pkg::TABLE_SIZE;
        idx = (base + cgct_pkg::TABLE_SIZE - rot) % cgct_pkg::TABLE_SIZE;
        if (grad_stale) rebuild_gradient();
        r.red   = 8'(grad_table[idx][0]);
        r.green = 8'(grad_table[idx][1]);
        r.blue  = 8'(grad_table[idx][2]);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one request, wait for acceptance, queue its expected response
  task automatic send_request(req_row_t q);
    colour_resp_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {4'd0, q.frac, q.blue, q.green, q.red, q.pos, q.op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    r = predict_colour(q);
    // Typed rows are checked against their own expected response
    if (q.typed) r = q.resp;
    pending_colours = {pending_colours, r};
    @(negedge clk);
  endtask

  task automatic send_fields(logic [1:0] op, logic [9:0] pos, logic [23:0] rgb,
                             logic [15:0] frac);
    req_row_t q;
    q = '{op, pos, rgb[7:0], rgb[15:8], rgb[23:16], frac, 1'b0, '{0, 0, 0, 0}};
    send_request(q);
  endtask

  // Wait until every response is back, then write rotation while idle
  task automatic set_rotation(logic [9:0] value);
    in_tvalid <= 1'b0;
    while (pending_colours.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    grad_rot = value;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Response checker
  always @(posedge clk) begin
    colour_resp_t exp_c;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_colours.size() == 0) begin
        $error("response with nothing expected: %h", out_tdata);
        fail_count++;
      end else begin
        exp_c = pending_colours.pop_front();
        if (out_tdata[7:0] != exp_c.red) begin
          $error("out_red expected %0d actual %0d", exp_c.red, out_tdata[7:0]);
          fail_count++;
        end
        if (out_tdata[15:8] != exp_c.green) begin
          $error("out_green expected %0d actual %0d", exp_c.green, out_tdata[15:8]);
          fail_count++;
        end
        if (out_tdata[23:16] != exp_c.blue) begin
          $error("out_blue expected %0d actual %0d", exp_c.blue, out_tdata[23:16]);
          fail_count++;
        end
        if (out_tdata[24] != exp_c.status) begin
          $error("status expected %0d actual %0d", exp_c.status, out_tdata[24]);
          fail_count++;
        end
      end
    end
  end

  // Overall time limit
  initial begin
    #60ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    req_row_t directed [14] = '{
      '{cgct_pkg::OP_LOOKUP, 10'd0,    8'd0,   8'd0,   8'd0,   16'h0000, 1'b1,
        '{0, 0, 0, 0}},
      '{OP_UNUSED,           10'h3FF,  8'hFF,  8'hFF,  8'hFF,  16'hFFFF, 1'b1,
        '{0, 0, 0, 0}},
      '{cgct_pkg::OP_ADD,    10'd1023, 8'd255, 8'd0,   8'd0,   16'h0000, 1'b1,
        '{0, 0, 0, 0}},
      '{cgct_pkg::OP_LOOKUP, 10'd0,    8'd0,   8'd0,   8'd0,   16'h0000, 1'b1,
        '{255, 0, 0, 0}},
      '{cgct_pkg::OP_LOOKUP, 10'd0,    8'd0,   8'd0,   8'd0,   16'hFFFF, 1'b1,
        '{255, 0, 0, 0}},
      '{cgct_pkg::OP_ADD,    10'd0,    8'd0,   8'd255, 8'd0,   16'h0000, 1'b1,
        '{0, 0, 0, 0}},
      '{cgct_pkg::OP_ADD,    10'd0,    8'd0,   8'd0,   8'd255, 16'h0000, 1'b1,
        '{0, 0, 0, 0}},
      '{cgct_pkg::OP_ADD,    10'd512,  8'd255, 8'd255, 8'd255, 16'h0000, 1'b1,
        '{0, 0, 0, 0}},
      '{cgct_pkg::OP_LOOKUP, 10'd0,    8'd0,   8'd0,   8'd0,   16'h0000, 1'b0,
        '{0, 0, 0, 0}},
      '{cgct_pkg::OP_LOOKUP, 10'd0,    8'd0,   8'd0,   8'd0,   16'h8000, 1'b0,
        '{0, 0, 0, 0}},
      '{cgct_pkg::OP_LOOKUP, 10'd0,    8'd0,   8'd0,   8'd0,   16'hC123, 1'b0,
        '{0, 0, 0, 0}},
      '{cgct_pkg::OP_LOOKUP, 10'd0,    8'd0,   8'd0,   8'd0,   16'hFFFF, 1'b0,
        '{0, 0, 0, 0}},
      '{cgct_pkg::OP_CLEAR,  10'd0,    8'd0,   8'd0,   8'd0,   16'h0000, 1'b1,
        '{0, 0, 0, 0}},
      '{cgct_pkg::OP_LOOKUP, 10'd0,    8'd0,   8'd0,   8'd0,   16'h4000, 1'b1,
        '{0, 0, 0, 0}}
    };
    int n_adds, n_looks;

    grad_count = 0;
    grad_stale = 1'b1;
    grad_rot = 0;
    for (int i = 0; i < cgct_pkg::TABLE_SIZE; i++)
      for (int c = 0; c < 3; c++) grad_table[i][c] = 0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_request(directed[i]);

    // Fill the store: sixteen adds accepted, the next two rejected
    for (int i = 0; i < cgct_pkg::MAX_STOPS + 2; i++)
      send_fields(cgct_pkg::OP_ADD, 10'($urandom_range(1023)), 24'($urandom), 16'h0);
    send_fields(cgct_pkg::OP_LOOKUP, 10'd0, 24'd0, 16'h0000);
    send_fields(cgct_pkg::OP_LOOKUP, 10'd0, 24'd0, 16'hFFFF);

    // Random phases: rotation and idling change at each boundary
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_rotation(10'd0);
        1: set_rotation(10'd1023);
        2: set_rotation(10'd512);
        3: set_rotation(10'd3);
        default: set_rotation(10'($urandom_range(1023)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (ph == 1) hold_off_req = 1'b1;
      for (int seq = 0; seq < 7; seq++) begin
        // Sequence: optional clear, 0 to 18 adds, then 20 to 45 lookups, some after an unused op
        if ($urandom_range(2) == 0)
          send_fields(cgct_pkg::OP_CLEAR, 10'($urandom), 24'($urandom), 16'($urandom));
        n_adds = ($urandom_range(7) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 5);
        for (int a = 0; a < n_adds; a++)
          send_fields(cgct_pkg::OP_ADD, 10'($urandom), 24'($urandom), 16'($urandom));
        n_looks = $urandom_range(20, 45);
        for (int l = 0; l < n_looks; l++) begin
          if ($urandom_range(19) == 0)
            send_fields(OP_UNUSED, 10'($urandom), 24'($urandom), 16'($urandom));
          send_fields(cgct_pkg::OP_LOOKUP, 10'($urandom), 24'($urandom), 16'($urandom));
        end
      end
    end

    // Drain: wait for all responses, then a short settle
    in_tvalid <= 1'b0;
    while (pending_colours.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
